### hw/rtl/zba_pkg.sv
// Shared constants, command codes and item types of the zone bitmap allocator.
`default_nettype none
package zba_pkg;

   localparam int MAP_BYTES  = 1024;
   localparam int WORD_BYTES = 8;
   localparam int WORD_W     = WORD_BYTES * 8;
   localparam int ROWS       = MAP_BYTES / WORD_BYTES;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int LANE_W     = $clog2(WORD_BYTES);
   localparam int BIT_SEL_W  = $clog2(WORD_W);
   localparam int MAP_BITS   = MAP_BYTES * 8;
   localparam int CNT_W      = 14;
   localparam int BLK_W      = 16;
   localparam int IDX_W      = 10;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CNT_W-1:0] BITS_IN_USE_RESET = CNT_W'(8192);

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_FREE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_FIRST_ZONE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BITS_IN_USE = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       byte_value;
   } req_item_type;

   typedef struct packed {
      logic             status;
      logic [BLK_W-1:0] block_number;
      logic [7:0]       read_byte;
   } rsp_item_type;

   typedef struct packed {
      logic                 found;
      logic                 overflow;
      logic                 last;
      logic [BIT_SEL_W-1:0] bit_sel;
      logic [BLK_W-1:0]     block_number;
   } scan_res_type;

endpackage
`default_nettype wire

### hw/rtl/zone_bitmap_allocator.sv
// Zone bitmap allocator top level: sequencer, configuration and result register.
// A load or read item passes through these steps before the earliest next acceptance:
// the map row is read (one registered read), merged or selected, and the result is loaded
// into the output register. An allocate item scans one 64-bit map row per cycle through the
// scan unit, first row first; the number of rows scanned is 1 to 128. A result still
// waiting in the output register holds the next one back while rsp_ready stays low.
// The map resets to all free at once through per-row valid bits; no clearing pass.
// The block takes one item at a time; req_ready is high only while the sequencer is idle.
`default_nettype none
module zone_bitmap_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire zba_pkg::req_item_type            req_item,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output zba_pkg::rsp_item_type                 rsp_item,
   input  wire logic                             csr_we,
   input  wire logic [zba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [zba_pkg::BLK_W-1:0]        csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [zba_pkg::BLK_W-1:0]      first_zone_ff;
   logic [zba_pkg::CNT_W-1:0]      bits_in_use_ff;
   logic [zba_pkg::CNT_W-1:0]      limit;
   logic [zba_pkg::ROW_W-1:0]      row_ff, row_in;
   logic [zba_pkg::LANE_W-1:0]     lane_ff, lane_in;
   logic [7:0]                     val_ff, val_in;
   zba_pkg::rsp_item_type          res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   zba_pkg::rsp_item_type          rsp_item_ff, rsp_item_in;
   logic [zba_pkg::ROW_W-1:0]      ram_rd_addr;
   logic [zba_pkg::WORD_W-1:0]     ram_rd_data;
   logic                           ram_we;
   logic [zba_pkg::WORD_W-1:0]     ram_wr_data;
   zba_pkg::scan_res_type          scan;
   logic                           accept;
   logic [zba_pkg::WORD_W-1:0]     merged;
   logic [7:0]                     sel_byte;

   zba_map_ram u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_we),
      .wr_addr (row_ff),
      .wr_data (ram_wr_data)
   );

   zba_scan u_scan (
      .word       (ram_rd_data),
      .row        (row_ff),
      .limit      (limit),
      .first_zone (first_zone_ff),
      .res        (scan)
   );

   assign limit = (bits_in_use_ff > zba_pkg::CNT_W'(zba_pkg::MAP_BITS))
                ? zba_pkg::CNT_W'(zba_pkg::MAP_BITS) : bits_in_use_ff;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;

   always_comb begin
      merged   = ram_rd_data;
      sel_byte = '0;
      for (int k = 0; k < zba_pkg::WORD_BYTES; k++) begin
         if (zba_pkg::LANE_W'(k) == lane_ff) begin
            merged[k*8 +: 8] = val_ff;
            sel_byte         = ram_rd_data[k*8 +: 8];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      lane_in      = lane_ff;
      val_in       = val_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      ram_rd_addr  = row_ff;
      ram_we       = 1'b0;
      ram_wr_data  = merged;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_item.cmd == zba_pkg::CMD_ALLOC) begin
               ram_rd_addr = '0;
            end else begin
               ram_rd_addr = req_item.byte_index[zba_pkg::IDX_W-1:zba_pkg::LANE_W];
            end
            if (accept) begin
               row_in  = ram_rd_addr;
               lane_in = req_item.byte_index[zba_pkg::LANE_W-1:0];
               val_in  = req_item.byte_value;
               res_in  = '0;
               case (req_item.cmd)
                  zba_pkg::CMD_LOAD:  state_in = ST_LOAD;
                  zba_pkg::CMD_ALLOC: state_in = ST_SCAN;
                  zba_pkg::CMD_READ:  state_in = ST_READ;
                  default:            state_in = ST_DONE;
               endcase
            end
         end
         ST_LOAD: begin
            ram_we   = 1'b1;
            state_in = ST_DONE;
         end
         ST_READ: begin
            res_in.read_byte = sel_byte;
            state_in         = ST_DONE;
         end
         ST_SCAN: begin
            ram_rd_addr = zba_pkg::ROW_W'(row_ff + 1'b1);
            if (scan.found) begin
               if (scan.overflow) begin
                  res_in.status = zba_pkg::STATUS_NO_FREE;
               end else begin
                  ram_we              = 1'b1;
                  ram_wr_data         = ram_rd_data
                                      | (zba_pkg::WORD_W'(1) << scan.bit_sel);
                  res_in.block_number = scan.block_number;
               end
               state_in = ST_DONE;
            end else if (scan.last) begin
               res_in.status = zba_pkg::STATUS_NO_FREE;
               state_in      = ST_DONE;
            end else begin
               row_in = ram_rd_addr;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         first_zone_ff  <= '0;
         bits_in_use_ff <= zba_pkg::BITS_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               zba_pkg::REG_FIRST_ZONE:  first_zone_ff  <= csr_wdata;
               zba_pkg::REG_BITS_IN_USE: bits_in_use_ff <= csr_wdata[zba_pkg::CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      lane_ff     <= lane_in;
      val_ff      <= val_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // one item at a time: an accepted item closes the input until its result is posted
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("input accepted while an item is in progress");

   // the map is only written while an item is at work
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("map write while idle");

   // a failed allocate reports no block number
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status) |-> (rsp_item.block_number == '0))
      else $error("failed allocate carries a block number");

endmodule
`default_nettype wire

### hw/rtl/zba_map_ram.sv
// Free map storage: one row of map bytes per entry, with per-row valid bits.
`default_nettype none
module zba_map_ram (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [zba_pkg::ROW_W-1:0]      rd_addr,
   output logic      [zba_pkg::WORD_W-1:0]     rd_data,
   input  wire logic                           wr_en,
   input  wire logic [zba_pkg::ROW_W-1:0]      wr_addr,
   input  wire logic [zba_pkg::WORD_W-1:0]     wr_data
);

   logic [zba_pkg::WORD_W-1:0] mem [zba_pkg::ROWS];
   logic [zba_pkg::WORD_W-1:0] rd_q_ff;
   logic [zba_pkg::ROWS-1:0]   valid_ff;
   logic                       rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   // rows never written read as all free
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule
`default_nettype wire

### hw/rtl/zba_scan.sv
// Row scan unit: masks bits past the limit, finds the first clear bit, forms the block number.
`default_nettype none
module zba_scan (
   input  wire logic [zba_pkg::WORD_W-1:0] word,
   input  wire logic [zba_pkg::ROW_W-1:0]  row,
   input  wire logic [zba_pkg::CNT_W-1:0]  limit,
   input  wire logic [zba_pkg::BLK_W-1:0]  first_zone,
   output zba_pkg::scan_res_type           res
);

   logic [zba_pkg::WORD_W-1:0]               eff;
   logic [zba_pkg::ROW_W+zba_pkg::BIT_SEL_W-1:0] pos;
   logic [zba_pkg::CNT_W-1:0]                row_end;
   logic                                     hit;
   logic [zba_pkg::BIT_SEL_W-1:0]            sel;
   logic [zba_pkg::BLK_W:0]                  sum;

   always_comb begin
      eff = word;
      for (int j = 0; j < zba_pkg::WORD_W; j++) begin
         pos = {row, zba_pkg::BIT_SEL_W'(j)};
         if (zba_pkg::CNT_W'(pos) >= limit) begin
            eff[j] = 1'b1;
         end
      end
   end

   always_comb begin
      hit = 1'b0;
      sel = '0;
      for (int j = zba_pkg::WORD_W - 1; j >= 0; j--) begin
         if (!eff[j]) begin
            hit = 1'b1;
            sel = zba_pkg::BIT_SEL_W'(j);
         end
      end
   end

   assign row_end = zba_pkg::CNT_W'({row, zba_pkg::BIT_SEL_W'(0)})
                  + zba_pkg::CNT_W'(zba_pkg::WORD_W);
   assign sum     = {1'b0, first_zone} + (zba_pkg::BLK_W+1)'({row, sel});

   assign res.found        = hit;
   assign res.overflow     = sum[zba_pkg::BLK_W];
   assign res.last         = (row_end >= limit);
   assign res.bit_sel      = sel;
   assign res.block_number = sum[zba_pkg::BLK_W-1:0];

endmodule
`default_nettype wire
